// ===== src/bcld_pkg.sv =====
package bcld_pkg;

    // fixed field widths
    localparam int BLK_W      = 32;
    localparam int CAP_W      = 5;
    localparam int LEN_W      = 24;
    localparam int SRC_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_TOTAL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BYTES = 2'd3;

    // register reset values
    localparam logic [CAP_W-1:0] CAP_RST = 5'd16;
    localparam logic [LEN_W-1:0] LEN_RST = 24'd32768;
    localparam logic [LEN_W-1:0] TRIM_RST = 24'd0;
    localparam logic [SRC_W-1:0] SRC_RST = 48'd0;

    // action codes
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_CMP,
        F_SEND
    } fe_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_TAIL,
        B_DECIDE
    } be_state_t;

    // classified command from front to back
    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] block;
        logic             redo;
        logic             fits;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic             success;
        logic             was_resident;
        logic             need_fetch;
        logic             need_process;
        logic             evict_valid;
        logic [BLK_W-1:0] evicted_block;
    } res_t;

endpackage

// ===== src/bcld_queue.sv =====
module bcld_queue
    import bcld_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == 2'(DEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bcld_front.sv =====
module bcld_front
    import bcld_pkg::*;
#(
    parameter int BLOCK_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             action,
    input  logic [BLK_W-1:0] block_number,
    input  logic             redo,
    input  logic [LEN_W-1:0] block_length,
    input  logic [LEN_W-1:0] trim_total,
    input  logic [SRC_W-1:0] source_bytes,
    output logic             cmd_push,
    output cmd_t             cmd_data,
    input  logic             cmd_full
);

    localparam int TAG_W  = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
    localparam int PROD_W = TAG_W + LEN_W;
    localparam int SUM_W  = (PROD_W + 1 > SRC_W) ? PROD_W + 1 : SRC_W;

    fe_state_t         state_reg;
    fe_state_t         state_next;
    logic              action_reg;
    logic [TAG_W-1:0]  blk_reg;
    logic              force_reg;
    logic [PROD_W-1:0] product_reg;
    logic              fits_reg;
    logic [LEN_W-1:0]  stride;
    logic              fits_next;
    logic              accept;

    assign full   = (state_reg != F_IDLE);
    assign accept = push && !full;

    // stride is length minus trim, zero when the trim swallows the block
    assign stride = (block_length > trim_total) ? (block_length - trim_total) : '0;

    // offset plus length within the source, exact so no overflow check needed
    assign fits_next = (SUM_W'(product_reg) + SUM_W'(block_length)) <= SUM_W'(source_bytes);

    always_comb
    begin
        state_next          = state_reg;
        cmd_push            = 1'b0;
        cmd_data.action     = action_reg;
        cmd_data.block      = BLK_W'(blk_reg);
        cmd_data.redo       = force_reg;
        cmd_data.fits       = fits_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_CMP;
            end
            F_CMP:
            begin
                state_next = F_SEND;
            end
            F_SEND:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            blk_reg    <= block_number[TAG_W-1:0];
            force_reg  <= redo;
        end
        if (state_reg == F_MUL)
        begin
            product_reg <= PROD_W'(blk_reg) * PROD_W'(stride);
        end
        if (state_reg == F_CMP)
        begin
            fits_reg <= fits_next;
        end
    end

endmodule

// ===== src/bcld_back.sv =====
module bcld_back
    import bcld_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  cmd_t             cmd_data,
    input  logic [CAP_W-1:0] capacity,
    output logic             res_push,
    output res_t             res_data,
    input  logic             res_full
);

    localparam int TAG_W  = (BLOCK_BITS < BLK_W) ? BLOCK_BITS : BLK_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    be_state_t          state_reg;
    be_state_t          state_next;
    cmd_t               cmd_reg;

    // tag store, one read and one write port
    logic [TAG_W-1:0]   tag_mem [ENTRIES];
    logic [TAG_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] proc_reg;
    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [CNT_W-1:0]   count_reg;

    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [RANK_W-1:0]  hit_rank_reg;
    logic               hit_proc_reg;
    logic               vic_found_reg;
    logic [IDX_W-1:0]   vic_idx_reg;
    logic [TAG_W-1:0]   vic_tag_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               cur_valid;
    logic [RANK_W-1:0]  cur_rank;
    logic               tag_match;
    logic               is_oldest;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               evicting;
    logic [IDX_W-1:0]   slot;
    logic               is_flush;
    logic               do_hit;
    logic               do_insert;

    // per-entry view of the tag coming out of the store
    assign cur_valid = valid_reg[rd_idx_reg];
    assign cur_rank  = rank_reg[rd_idx_reg];
    assign tag_match = (rd_data_reg == cmd_reg.block[TAG_W-1:0]);
    assign is_oldest = cur_valid && (CNT_W'(cur_rank) == (count_reg - CNT_W'(1)));

    // capacity clamped to 1 .. ENTRIES
    assign cap_ext = CMP_W'(capacity);
    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evicting  = (CMP_W'(count_reg) >= eff_cap) && vic_found_reg;
    assign slot      = evicting ? vic_idx_reg : free_idx_reg;
    assign is_flush  = (cmd_reg.action == ACT_FLUSH);
    assign do_hit    = !is_flush && hit_found_reg;
    assign do_insert = !is_flush && !hit_found_reg && cmd_reg.fits;

    always_comb
    begin
        res_data.success       = do_hit || do_insert;
        res_data.was_resident  = do_hit;
        res_data.need_fetch    = do_insert;
        res_data.need_process  = do_insert ||
                                 (do_hit && (!hit_proc_reg || cmd_reg.redo));
        res_data.evict_valid   = do_insert && evicting;
        res_data.evicted_block = (do_insert && evicting) ? BLK_W'(vic_tag_reg) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = (cmd_data.action == ACT_FLUSH) ? B_DECIDE : B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (scan_reg == LAST_IDX)
                begin
                    state_next = B_TAIL;
                end
            end
            B_TAIL:
            begin
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == B_SCAN);
            if (cmd_pop)
            begin
                scan_reg       <= '0;
                hit_found_reg  <= 1'b0;
                vic_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == B_SCAN)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (cur_valid && tag_match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    if (is_oldest)
                    begin
                        vic_found_reg <= 1'b1;
                    end
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // scan captures, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        if (state_reg == B_SCAN)
        begin
            rd_idx_reg <= scan_reg;
        end
        if (rd_vld_reg)
        begin
            if (cur_valid && tag_match && !hit_found_reg)
            begin
                hit_idx_reg  <= rd_idx_reg;
                hit_rank_reg <= cur_rank;
                hit_proc_reg <= proc_reg[rd_idx_reg];
            end
            if (is_oldest)
            begin
                vic_idx_reg <= rd_idx_reg;
                vic_tag_reg <= rd_data_reg;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_SCAN)
        begin
            rd_data_reg <= tag_mem[scan_reg];
        end
        if (res_push && do_insert)
        begin
            tag_mem[slot] <= cmd_reg.block[TAG_W-1:0];
        end
    end

    // directory state: valid, processed marks, recency ranks, fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            proc_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (res_push)
        begin
            if (is_flush)
            begin
                proc_reg <= '0;
            end
            else if (do_hit)
            begin
                proc_reg[hit_idx_reg] <= 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == hit_idx_reg)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
            else if (do_insert)
            begin
                valid_reg[slot] <= 1'b1;
                proc_reg[slot]  <= 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == slot)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
                if (!evicting)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count out of step with valid entries");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == B_SCAN || state_reg == B_TAIL))
        else $error("tag read data outside the scan");

    a_free_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && do_insert && !evicting) |-> !valid_reg[slot])
        else $error("insert into an occupied entry without eviction");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && do_hit) |-> valid_reg[hit_idx_reg])
        else $error("hit on an invalid entry");

endmodule

// ===== src/block_cache_lru_directory.sv =====
// flow: the front multiplies and compares, the command queue buffers, the back scans
//   the tags and decides; a flush skips the scan in the back but still passes the front
// pace: set by the tag memory scan at one entry per cycle; the front takes a new
//   request only once it has sent the last one into the command queue
// reset: registers return to capacity 16, length 32768, trim 0, source 0; the directory
//   is empty at once (valid bits cleared), no clearing pass, tag memory left as is
module block_cache_lru_directory
    import bcld_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int BLOCK_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // request side, queue style
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [BLK_W-1:0]      block_number,
    input  logic                  redo,

    // result side, queue style
    output logic                  empty,
    input  logic                  pop,
    output logic                  success,
    output logic                  was_resident,
    output logic                  need_fetch,
    output logic                  need_process,
    output logic                  evict_valid,
    output logic [BLK_W-1:0]      evicted_block,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CAP_W-1:0] cap_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] trim_reg;
    logic [SRC_W-1:0] src_reg;

    // front to command queue
    logic             cmd_push;
    cmd_t             cmd_wr;
    logic             cmd_full;

    // command queue to back
    logic             cmd_pop;
    cmd_t             cmd_rd;
    logic             cmd_empty;

    // back to result queue
    logic             res_push;
    res_t             res_wr;
    logic             res_full;
    res_t             res_rd;

    // writes always taken, unchecked: use the port only while the block is idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RST;
            len_reg  <= LEN_RST;
            trim_reg <= TRIM_RST;
            src_reg  <= SRC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAPACITY:     cap_reg  <= cfg_data[CAP_W-1:0];
                CFG_BLOCK_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                CFG_TRIM_TOTAL:   trim_reg <= cfg_data[LEN_W-1:0];
                CFG_SOURCE_BYTES: src_reg  <= cfg_data[SRC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: takes each transaction, masks the block number and checks whether a
    // missing block would still lie inside the source
    bcld_front #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .block_number (block_number),
        .redo         (redo),
        .block_length (len_reg),
        .trim_total   (trim_reg),
        .source_bytes (src_reg),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_wr),
        .cmd_full     (cmd_full)
    );

    // short command queue so the front keeps classifying while the back scans
    bcld_queue #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_wr),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_rd),
        .empty     (cmd_empty)
    );

    // back: tag scan (none for a flush), then hit, insert, evict or flush in one step
    bcld_back #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_rd),
        .capacity  (cap_reg),
        .res_push  (res_push),
        .res_data  (res_wr),
        .res_full  (res_full)
    );

    // result queue parts the back from a stalled consumer
    bcld_queue #(
        .WIDTH ($bits(res_t))
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_wr),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_rd),
        .empty     (empty)
    );

    assign success       = res_rd.success;
    assign was_resident  = res_rd.was_resident;
    assign need_fetch    = res_rd.need_fetch;
    assign need_process  = res_rd.need_process;
    assign evict_valid   = res_rd.evict_valid;
    assign evicted_block = res_rd.evicted_block;

endmodule

// ===== sim/bcld_checker.sv =====
`timescale 1ns / 1ps

module bcld_checker
    import bcld_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  push,
    input  logic                  full,
    input  logic                  action,
    input  logic [BLK_W-1:0]      block_number,
    input  logic                  redo,

    input  logic                  empty,
    input  logic                  pop,
    input  logic                  success,
    input  logic                  was_resident,
    input  logic                  need_fetch,
    input  logic                  need_process,
    input  logic                  evict_valid,
    input  logic [BLK_W-1:0]      evicted_block,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    outstanding
);

    // shadow registers
    logic [CAP_W-1:0] shadow_cap;
    logic [LEN_W-1:0] shadow_len;
    logic [LEN_W-1:0] shadow_trim;
    logic [SRC_W-1:0] shadow_src;

    // shadow directory
    logic [BLK_W-1:0] dir_tag   [ENTRIES];
    logic             dir_valid [ENTRIES];
    logic             dir_done  [ENTRIES];
    int               dir_age   [ENTRIES];

    res_t results_due[$];

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic bit block_in_source(logic [BLK_W-1:0] blk);
        longint unsigned len;
        longint unsigned trim;
        longint unsigned src;
        longint unsigned stride;
        longint unsigned offset;
        len = 64'(shadow_len);
        trim = 64'(shadow_trim);
        src = 64'(shadow_src);
        stride = (len > trim) ? len - trim : 0;
        if (stride != 0 && 64'(blk) > src / stride)
            return 1'b0;
        offset = 64'(blk) * stride;
        return (offset + len <= src);
    endfunction

    // updates the shadow directory and returns the expected result
    function automatic res_t resolve_access(logic act, logic [BLK_W-1:0] blk, logic frc);
        res_t r;
        int   hit;
        int   victim;
        int   slot;
        int   count;
        int   cap;
        r = '0;
        hit = -1;
        victim = -1;
        slot = -1;
        count = 0;
        if (act == ACT_FLUSH)
        begin
            foreach (dir_done[i])
                dir_done[i] = 1'b0;
            return r;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (dir_valid[i])
            begin
                count++;
                if (hit < 0 && dir_tag[i] == blk)
                    hit = i;
                if (victim < 0 || dir_age[i] > dir_age[victim])
                    victim = i;
            end
        end
        if (hit >= 0)
        begin
            r.success = 1'b1;
            r.was_resident = 1'b1;
            r.need_process = !dir_done[hit] || frc;
            dir_done[hit] = 1'b1;
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && dir_age[i] < dir_age[hit])
                    dir_age[i]++;
            dir_age[hit] = 0;
            return r;
        end
        if (!block_in_source(blk))
            return r;
        cap = int'(shadow_cap);
        if (cap == 0)
            cap = 1;
        if (cap > ENTRIES)
            cap = ENTRIES;
        if (count >= cap && victim >= 0)
        begin
            r.evict_valid = 1'b1;
            r.evicted_block = dir_tag[victim];
            dir_valid[victim] = 1'b0;
            slot = victim;
        end
        else
        begin
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (!dir_valid[i])
                    slot = i;
        end
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i])
                dir_age[i]++;
        dir_tag[slot] = blk;
        dir_valid[slot] = 1'b1;
        dir_done[slot] = 1'b1;
        dir_age[slot] = 0;
        r.success = 1'b1;
        r.need_fetch = 1'b1;
        r.need_process = 1'b1;
        return r;
    endfunction

    task automatic note_field(string fname, logic [BLK_W-1:0] want, logic [BLK_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch on %s, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            shadow_cap = CAP_RST;
            shadow_len = LEN_RST;
            shadow_trim = TRIM_RST;
            shadow_src = SRC_RST;
            foreach (dir_valid[i])
            begin
                dir_tag[i] = '0;
                dir_valid[i] = 1'b0;
                dir_done[i] = 1'b0;
                dir_age[i] = 0;
            end
            results_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY:     shadow_cap = cfg_data[CAP_W-1:0];
                    CFG_BLOCK_LENGTH: shadow_len = cfg_data[LEN_W-1:0];
                    CFG_TRIM_TOTAL:   shadow_trim = cfg_data[LEN_W-1:0];
                    CFG_SOURCE_BYTES: shadow_src = cfg_data[SRC_W-1:0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want = results_due.pop_front();
                    note_field("success", want.success, success);
                    note_field("was_resident", want.was_resident, was_resident);
                    note_field("need_fetch", want.need_fetch, need_fetch);
                    note_field("need_process", want.need_process, need_process);
                    note_field("evict_valid", want.evict_valid, evict_valid);
                    note_field("evicted_block", want.evicted_block, evicted_block);
                end
            end
            if (push && !full)
                results_due.push_back(resolve_access(action, block_number, redo));
        end
        outstanding = results_due.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bcld_pkg::*;

    localparam int ENTRIES = 16;
    // push to result on an idle block, with some margin
    localparam int SETTLE_CYCLES = ENTRIES + 16;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  action = ACT_ACCESS;
    logic [BLK_W-1:0]      block_number = '0;
    logic                  redo = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  success;
    logic                  was_resident;
    logic                  need_fetch;
    logic                  need_process;
    logic                  evict_valid;
    logic [BLK_W-1:0]      evicted_block;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int outstanding;

    // percentage of cycles in which each side holds back
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    block_cache_lru_directory #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLK_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .block_number  (block_number),
        .redo          (redo),
        .empty         (empty),
        .pop           (pop),
        .success       (success),
        .was_resident  (was_resident),
        .need_fetch    (need_fetch),
        .need_process  (need_process),
        .evict_valid   (evict_valid),
        .evicted_block (evicted_block),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // watches both queues and the register channel, predicts and compares
    bcld_checker #(
        .ENTRIES (ENTRIES)
    ) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .block_number  (block_number),
        .redo          (redo),
        .empty         (empty),
        .pop           (pop),
        .success       (success),
        .was_resident  (was_resident),
        .need_fetch    (need_fetch),
        .need_process  (need_process),
        .evict_valid   (evict_valid),
        .evicted_block (evicted_block),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // result side: one decision per cycle, so pop is only ever assigned once per step
    always @(negedge clk)
        pop <= ($urandom_range(99) >= take_idle_pct);

    // one request transaction; called at a falling edge, returns at a falling edge
    // with push still high so back-to-back requests need no second assignment
    task automatic send_request(input logic act, input logic [BLK_W-1:0] blk,
                                input logic frc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        action <= act;
        block_number <= blk;
        redo <= frc;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop requesting, collect every outstanding result and let the back end go quiet
    task automatic drain_results();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // registers are only rewritten once the block has gone idle
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] cap_word,
                               input logic [CFG_DATA_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] trim,
                               input logic [CFG_DATA_W-1:0] src);
        drain_results();
        write_register(CFG_CAPACITY, cap_word);
        write_register(CFG_BLOCK_LENGTH, len);
        write_register(CFG_TRIM_TOTAL, trim);
        write_register(CFG_SOURCE_BYTES, src);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        longint unsigned        len;
        longint unsigned        trim;
        longint unsigned        stride;
        longint unsigned        src;
        int                     reach;
        int                     pick;
        logic [CFG_DATA_W-1:0]  cap_word;
        logic                   frc;

        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: source size 0, so nothing fits
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b0);
        send_request(ACT_FLUSH, 32'h0000_0000, 1'b0);

        // two entries, one-byte blocks, widest source: every block number fits
        reconfigure(48'd2, 48'd1, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b0);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b0);  // hit, already processed
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b1);  // hit, forced redo
        send_request(ACT_ACCESS, 32'h0000_0005, 1'b0);  // evicts the all-ones block
        send_request(ACT_FLUSH, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b0);  // hit after flush wants processing
        send_request(ACT_ACCESS, 32'hA5A5_A5A5, 1'b1);
        send_request(ACT_ACCESS, 32'h5A5A_5A5A, 1'b0);

        // capacity 0 behaves as 1 while two entries are still resident;
        // widest length with trim one below gives a stride of 1, blocks 0..3 fit
        reconfigure(48'd0, 48'hFF_FFFF, 48'hFF_FFFE, 48'h0000_0100_0002);
        send_request(ACT_ACCESS, 32'h0000_0003, 1'b0);
        send_request(ACT_ACCESS, 32'h0000_0004, 1'b0);  // past the end of the source
        send_request(ACT_ACCESS, 32'h5A5A_5A5A, 1'b0);  // resident, source check skipped
        send_request(ACT_ACCESS, 32'h0000_0002, 1'b1);

        // trim above length: zero stride, everything starts at offset 0
        // capacity 31 is clamped to the entry count
        reconfigure(48'd31, 48'd100, 48'hFF_FFFE, 48'd100);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_ACCESS, 32'h1234_5678, 1'b1);
        send_request(ACT_ACCESS, 32'h0000_0000, 1'b0);

        // largest stride against the largest source: overflow guard and exact fit
        reconfigure(48'd16, 48'hFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_request(ACT_ACCESS, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_ACCESS, 32'h00FF_FFFF, 1'b0);
        send_request(ACT_ACCESS, 32'h0100_0000, 1'b0);  // ends on the last source byte
        send_request(ACT_ACCESS, 32'h0100_0001, 1'b0);

        // random traffic: three idling patterns, three settings each
        for (int mode = 0; mode < 3; mode++)
        begin
            for (int part = 0; part < 3; part++)
            begin
                len = $urandom_range(1, 4096);
                if ($urandom_range(5) == 0)
                    trim = len + $urandom_range(0, 8);
                else
                    trim = $urandom_range(0, len - 1);
                stride = (len > trim) ? len - trim : 0;
                // source sized so that roughly 'reach' blocks fit
                reach = $urandom_range(6, 40);
                if (stride != 0)
                    src = stride * reach + len + $urandom_range(0, stride - 1);
                else if ($urandom_range(3) == 0)
                    src = len - 1;
                else
                    src = len + $urandom_range(0, 1000);
                // junk above the capacity field must be ignored
                cap_word = CFG_DATA_W'({$urandom, $urandom});
                if ($urandom_range(3) == 0)
                    cap_word[CAP_W-1:0] = CAP_W'($urandom_range(0, 31));
                else
                    cap_word[CAP_W-1:0] = CAP_W'($urandom_range(1, 8));
                reconfigure(cap_word, CFG_DATA_W'(len), CFG_DATA_W'(trim),
                            CFG_DATA_W'(src));

                case (mode)
                    0:
                    begin
                        send_idle_pct = 19;
                        take_idle_pct = 51;
                    end
                    1:
                    begin
                        send_idle_pct = 51;
                        take_idle_pct = 19;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        take_idle_pct = 0;
                    end
                endcase

                // mostly block numbers near the source end, to mix hits, misses,
                // evictions and rejections; some flushes and full-width numbers
                repeat (50)
                begin
                    pick = $urandom_range(99);
                    frc = ($urandom_range(3) == 0);
                    if (pick < 8)
                        send_request(ACT_FLUSH, $urandom, frc);
                    else if (pick < 16)
                        send_request(ACT_ACCESS, $urandom, frc);
                    else
                        send_request(ACT_ACCESS, $urandom_range(0, reach + 3), frc);
                end
            end
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("[block_cache_lru_directory] OK");
        else
            $display("[block_cache_lru_directory] ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[block_cache_lru_directory] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bcld_pkg.sv
src/bcld_queue.sv
src/bcld_front.sv
src/bcld_back.sv
src/block_cache_lru_directory.sv
sim/bcld_checker.sv
sim/tb_top.sv
